@@ hw/rtl/qte_pkg.sv @@
// Shared types, constants and arithmetic helpers for the quadratic trace evaluator.
// Used by qte_hyp, qte_ash, the top level and the checker. No dependencies.
package qte_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COEF_FRAC  = 32;
    localparam int INT_FRAC   = FRAC_BITS + 14;
    localparam int DROP       = COEF_FRAC + FRAC_BITS - INT_FRAC;
    localparam int LEN_DROP   = 2 * INT_FRAC + 2 - FRAC_BITS - COEF_FRAC;
    localparam int COEF_W     = 48;
    localparam int IO_W       = 32;
    localparam int REG_IDX_W  = 2;

    localparam int SQRT_STEPS = 64;
    localparam int LN_STEPS   = 62;
    localparam int DIV_STEPS  = 32;
    localparam int REM_W      = COEF_W + DIV_STEPS;

    // register stages inside each unit and end to end
    localparam int HYP_LAT    = 3 + SQRT_STEPS + 1;
    localparam int ASH_LAT    = 3 + 2 * LN_STEPS + 3;
    localparam int PIPE_LAT   = 6 + HYP_LAT + ASH_LAT + 5 + DIV_STEPS + 1;

    localparam logic [REG_IDX_W-1:0] REG_COEFF_CONSTANT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_LINEAR    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_QUADRATIC = 2'd2;

    // ln 2 in Q2.62, truncated
    localparam logic [63:0] LN2_Q62 = 64'h2C5C_85FD_F473_DE6A;

    typedef struct packed {
        logic [63:0] p3;
        logic [63:0] p2;
        logic [63:0] p1;
        logic [63:0] p0;
    } t_pp;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat;

    // four 32x32 partial products of an unsigned 64x64 multiply
    function automatic t_pp pp_mul(input logic [63:0] a, input logic [63:0] b);
        t_pp r;
        r.p0 = 64'(a[31:0]) * 64'(b[31:0]);
        r.p1 = 64'(a[31:0]) * 64'(b[63:32]);
        r.p2 = 64'(a[63:32]) * 64'(b[31:0]);
        r.p3 = 64'(a[63:32]) * 64'(b[63:32]);
        return r;
    endfunction

    function automatic logic [127:0] pp_sum(input t_pp pp);
        return {pp.p3, 64'd0} + ({64'd0, pp.p1} << 32) + ({64'd0, pp.p2} << 32)
               + {64'd0, pp.p0};
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic t_sat sat32(input logic signed [127:0] v);
        t_sat r;
        if (v[127:31] == '0 || v[127:31] == '1) begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end else if (v[127]) begin
            r.ovf = 1'b1;
            r.val = 32'h8000_0000;
        end else begin
            r.ovf = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/qte_hyp.sv @@
// Pipelined sqrt(1 + v^2) with v signed, INT_FRAC fraction bits, one bit per stage.
// Depends on qte_pkg. One item per cycle.
module qte_hyp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_val,
    output logic        o_valid,
    output logic [63:0] o_val,
    output logic [62:0] o_root
);
    import qte_pkg::*;

    logic        r_h0_v, r_h1_v, r_out_v;
    logic [63:0] r_h0_m, r_h0_val, r_h1_val, r_out_val;
    t_pp         r_h1_pp;
    logic [62:0] r_out_root;

    logic         r_sq_v    [0:SQRT_STEPS];
    logic [127:0] r_sq_n    [0:SQRT_STEPS];
    logic [65:0]  r_sq_rem  [0:SQRT_STEPS];
    logic [63:0]  r_sq_root [0:SQRT_STEPS];
    logic [63:0]  r_sq_val  [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0_v    <= 1'b0;
            r_h1_v    <= 1'b0;
            r_sq_v[0] <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_h0_v    <= i_valid;
            r_h1_v    <= r_h0_v;
            r_sq_v[0] <= r_h1_v;
            r_out_v   <= r_sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_h0_m       <= mag64(i_val);
        r_h0_val     <= i_val;
        r_h1_pp      <= pp_mul(r_h0_m, r_h0_m);
        r_h1_val     <= r_h0_val;
        r_sq_n[0]    <= pp_sum(r_h1_pp) + (128'd1 << (2 * INT_FRAC));
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_val[0]  <= r_h1_val;
        // a root past 63 bits clamps to all ones
        r_out_root   <= r_sq_root[SQRT_STEPS][63] ? '1 : r_sq_root[SQRT_STEPS][62:0];
        r_out_val    <= r_sq_val[SQRT_STEPS];
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sq
        logic [65:0] cur, trial;
        assign cur   = {r_sq_rem[k-1][63:0], r_sq_n[k-1][127:126]};
        assign trial = {r_sq_root[k-1], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_n[k]   <= {r_sq_n[k-1][125:0], 2'b00};
            r_sq_val[k] <= r_sq_val[k-1];
            if (cur >= trial) begin
                r_sq_rem[k]  <= cur - trial;
                r_sq_root[k] <= {r_sq_root[k-1][62:0], 1'b1};
            end else begin
                r_sq_rem[k]  <= cur;
                r_sq_root[k] <= {r_sq_root[k-1][62:0], 1'b0};
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_val   = r_out_val;
    assign o_root  = r_out_root;

endmodule

@@ hw/rtl/qte_ash.sv @@
// Pipelined asinh(v) = sign(v) * ln(|v| + h), h = sqrt(1 + v^2), INT_FRAC fraction bits.
// Depends on qte_pkg. log2 by repeated squaring, two stages per fraction bit.
module qte_ash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_val,
    input  logic [62:0] i_hyp,
    output logic        o_valid,
    output logic [63:0] o_ash,
    output logic [63:0] o_val,
    output logic [62:0] o_hyp
);
    import qte_pkg::*;

    localparam int LN_SHIFT = 62 - INT_FRAC;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [5:0]  k;
        logic [62:0] f;
        logic [63:0] val;
        logic [62:0] hyp;
    } t_lnc;

    logic        r_a0_v, r_a1_v, r_fa_v, r_fb_v, r_fc_v;
    logic [63:0] r_a0_r, r_a1_r;
    t_lnc        r_a0_c, r_a1_c, r_fa_c, r_fb_c, r_fc_c;
    t_lnc        a1_c;
    logic [5:0]  a1_k;

    logic        r_ms_v [0:LN_STEPS];
    logic [63:0] r_ms_m [0:LN_STEPS];
    t_lnc        r_ms_c [0:LN_STEPS];
    logic        r_ps_v [0:LN_STEPS-1];
    t_pp         r_ps_pp[0:LN_STEPS-1];
    t_lnc        r_ps_c [0:LN_STEPS-1];

    t_pp         r_fa_pp;
    logic [67:0] r_fa_kk, r_fb_kk;
    logic [63:0] r_fb_prod;
    logic [63:0] r_fc_ash;
    logic [127:0] fb_full;
    logic [67:0] fc_acc, fc_accs;
    logic [63:0] fc_l;
    logic [5:0]  fa_km;

    // leading one of |v| + h
    always_comb begin
        a1_k = '0;
        for (int i = 0; i < 64; i++) begin
            if (r_a0_r[i]) begin
                a1_k = 6'(i);
            end
        end
    end

    always_comb begin
        a1_c      = r_a0_c;
        a1_c.k    = a1_k;
        a1_c.zero = (a1_k < 6'(INT_FRAC));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0_v    <= 1'b0;
            r_a1_v    <= 1'b0;
            r_ms_v[0] <= 1'b0;
            r_fa_v    <= 1'b0;
            r_fb_v    <= 1'b0;
            r_fc_v    <= 1'b0;
        end else begin
            r_a0_v    <= i_valid;
            r_a1_v    <= r_a0_v;
            r_ms_v[0] <= r_a1_v;
            r_fa_v    <= r_ms_v[LN_STEPS];
            r_fb_v    <= r_fa_v;
            r_fc_v    <= r_fb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0_r       <= mag64(i_val) + {1'b0, i_hyp};
        r_a0_c       <= '{neg: i_val[63], zero: 1'b0, k: '0, f: '0, val: i_val, hyp: i_hyp};

        r_a1_r       <= r_a0_r;
        r_a1_c       <= a1_c;

        // mantissa with its leading one at bit 62
        r_ms_m[0]    <= (r_a1_c.k == 6'd63) ? (r_a1_r >> 1) : (r_a1_r << (6'd62 - r_a1_c.k));
        r_ms_c[0]    <= r_a1_c;
    end

    for (genvar j = 0; j < LN_STEPS; j++) begin : g_ln
        logic [127:0] sq;
        logic [63:0]  t;
        t_lnc         nc;
        assign sq = pp_sum(r_ps_pp[j]);
        assign t  = sq[125:62];

        always_comb begin
            nc = r_ps_c[j];
            if (t[63]) begin
                nc.f[61 - j] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ps_v[j]   <= 1'b0;
                r_ms_v[j+1] <= 1'b0;
            end else begin
                r_ps_v[j]   <= r_ms_v[j];
                r_ms_v[j+1] <= r_ps_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ps_pp[j]  <= pp_mul(r_ms_m[j], r_ms_m[j]);
            r_ps_c[j]   <= r_ms_c[j];
            r_ms_c[j+1] <= nc;
            r_ms_m[j+1] <= t[63] ? (t >> 1) : t;
        end
    end

    assign fa_km   = r_ms_c[LN_STEPS].k - 6'(INT_FRAC);
    assign fb_full = pp_sum(r_fa_pp);
    assign fc_acc  = r_fb_kk + {4'd0, r_fb_prod};
    assign fc_accs = fc_acc >> LN_SHIFT;
    assign fc_l    = fc_accs[63:0];

    always_ff @(posedge i_clk) begin
        r_fa_pp   <= pp_mul({1'b0, r_ms_c[LN_STEPS].f}, LN2_Q62);
        r_fa_kk   <= {62'd0, fa_km} * {4'd0, LN2_Q62};
        r_fa_c    <= r_ms_c[LN_STEPS];
        r_fb_prod <= fb_full[125:62];
        r_fb_kk   <= r_fa_kk;
        r_fb_c    <= r_fa_c;
        if (r_fb_c.zero) begin
            r_fc_ash <= '0;
        end else begin
            r_fc_ash <= r_fb_c.neg ? (64'd0 - fc_l) : fc_l;
        end
        r_fc_c    <= r_fb_c;
    end

    assign o_valid = r_fc_v;
    assign o_ash   = r_fc_ash;
    assign o_val   = r_fc_c.val;
    assign o_hyp   = r_fc_c.hyp;

endmodule

@@ hw/rtl/quadratic_trace_evaluator.sv @@
// Quadratic trace evaluator: value, slope and arc length of y = a0 + a1*x + a2*x^2.
// One item accepted every cycle; each result is flagged on o_done.
// Pipeline depth is set by the 64-step square root, the 62-step logarithm and the 32-step divider.
// busy is high only while i_rst_n is low; results cannot be held off.
// Synchronous reset clears the coefficients and results to zero and drops every item in flight.
// Depends on qte_pkg, qte_hyp and qte_ash.
module quadratic_trace_evaluator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [qte_pkg::IO_W-1:0] i_abscissa,
    input  logic                           i_cfg_we,
    input  logic [qte_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qte_pkg::COEF_W-1:0]     i_cfg_wdata,
    output logic                           o_done,
    output logic signed [qte_pkg::IO_W-1:0] o_trace_value,
    output logic signed [qte_pkg::IO_W-1:0] o_trace_slope,
    output logic signed [qte_pkg::IO_W-1:0] o_path_length,
    output logic                           o_overflow
);
    import qte_pkg::*;

    localparam int SIDE_DLY = HYP_LAT + ASH_LAT;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] slope;
        logic        ovf;
        logic [31:0] x;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic        neg;
        logic        big;
        t_sat        lin;
    } t_tail;

    // coefficients
    logic signed [COEF_W-1:0] r_a0, r_a1, r_a2;
    logic signed [127:0]      a0_q, a1_q;
    logic [COEF_W-1:0]        a2_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEFF_CONSTANT:  r_a0 <= i_cfg_wdata;
                REG_COEFF_LINEAR:    r_a1 <= i_cfg_wdata;
                REG_COEFF_QUADRATIC: r_a2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign a0_q   = 128'(r_a0);
    assign a1_q   = 128'(r_a1);
    assign a2_mag = r_a2[COEF_W-1] ? (COEF_W'(0) - r_a2) : r_a2;
    assign busy   = ~i_rst_n;

    // polynomial front end
    logic               r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v;
    logic signed [31:0] r_a_x, r_b_x, r_c_x, r_d_x, r_e_x;
    t_pp                r_b_pp1, r_b_pp2, r_b_ppx, r_d_pp;
    logic               r_b_n1, r_b_n2;
    logic signed [127:0] r_c_a1x, r_c_a2x, r_d_d, r_d_vp, r_e_d, r_e_vp, r_e_a2xx;
    logic [63:0]        r_c_xx;
    logic [63:0]        b_xm;
    logic [127:0]       c_s1, c_s2, c_sx, e_s;
    logic signed [127:0] f_v, f_vsh, f_dsh, f_sfull, a1g_full;
    t_sat               f_sv, f_sd;
    logic [63:0]        r_f_s, r_f_a1g;
    t_side              r_f_side;

    assign b_xm     = mag64(64'(r_a_x));
    assign c_s1     = pp_sum(r_b_pp1);
    assign c_s2     = pp_sum(r_b_pp2);
    assign c_sx     = pp_sum(r_b_ppx);
    assign e_s      = pp_sum(r_d_pp);
    assign f_v      = r_e_vp + r_e_a2xx;
    assign f_vsh    = f_v >>> (COEF_FRAC + FRAC_BITS);
    assign f_dsh    = r_e_d >>> COEF_FRAC;
    assign f_sfull  = r_e_d >>> DROP;
    assign a1g_full = (a1_q <<< FRAC_BITS) >>> DROP;
    assign f_sv     = sat32(f_vsh);
    assign f_sd     = sat32(f_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            r_a_v <= start & ~busy;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x    <= i_abscissa;
        r_b_pp1  <= pp_mul(mag64(64'(r_a1)), b_xm);
        r_b_pp2  <= pp_mul(mag64(64'(r_a2)), b_xm);
        r_b_ppx  <= pp_mul(b_xm, b_xm);
        r_b_n1   <= r_a1[COEF_W-1] ^ r_a_x[31];
        r_b_n2   <= r_a2[COEF_W-1] ^ r_a_x[31];
        r_b_x    <= r_a_x;
        r_c_a1x  <= r_b_n1 ? -$signed(c_s1) : $signed(c_s1);
        r_c_a2x  <= r_b_n2 ? -$signed(c_s2) : $signed(c_s2);
        r_c_xx   <= c_sx[63:0];
        r_c_x    <= r_b_x;
        r_d_d    <= (a1_q <<< FRAC_BITS) + (r_c_a2x <<< 1);
        r_d_vp   <= (a0_q <<< (2 * FRAC_BITS)) + (r_c_a1x <<< FRAC_BITS);
        r_d_pp   <= pp_mul(64'(a2_mag), r_c_xx);
        r_d_x    <= r_c_x;
        r_e_a2xx <= r_a2[COEF_W-1] ? -$signed(e_s) : $signed(e_s);
        r_e_d    <= r_d_d;
        r_e_vp   <= r_d_vp;
        r_e_x    <= r_d_x;
        r_f_s    <= f_sfull[63:0];
        r_f_a1g  <= a1g_full[63:0];
        r_f_side <= '{value: f_sv.val, slope: f_sd.val, ovf: f_sv.ovf | f_sd.ovf, x: r_e_x};
    end

    // hypotenuse and asinh for s and for a1
    logic        hyp_s_v, hyp_a_v, ash_s_v, ash_a_v;
    logic [63:0] hyp_s_val, hyp_a_val, ash_s_val, ash_a_val, ash_s_ash, ash_a_ash;
    logic [62:0] hyp_s_root, hyp_a_root, ash_s_hyp, ash_a_hyp;

    qte_hyp u_hyp_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .i_val   (r_f_s),
        .o_valid (hyp_s_v),
        .o_val   (hyp_s_val),
        .o_root  (hyp_s_root)
    );

    qte_hyp u_hyp_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .i_val   (r_f_a1g),
        .o_valid (hyp_a_v),
        .o_val   (hyp_a_val),
        .o_root  (hyp_a_root)
    );

    qte_ash u_ash_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (hyp_s_v),
        .i_val   (hyp_s_val),
        .i_hyp   (hyp_s_root),
        .o_valid (ash_s_v),
        .o_ash   (ash_s_ash),
        .o_val   (ash_s_val),
        .o_hyp   (ash_s_hyp)
    );

    qte_ash u_ash_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (hyp_a_v),
        .i_val   (hyp_a_val),
        .i_hyp   (hyp_a_root),
        .o_valid (ash_a_v),
        .o_ash   (ash_a_ash),
        .o_val   (ash_a_val),
        .o_hyp   (ash_a_hyp)
    );

    // value, slope and x wait alongside the two units
    t_side r_side_dly [0:SIDE_DLY-1];

    always_ff @(posedge i_clk) begin
        r_side_dly[0] <= r_f_side;
        for (int i = 1; i < SIDE_DLY; i++) begin
            r_side_dly[i] <= r_side_dly[i-1];
        end
    end

    // closed form numerator
    logic               r_g_v, r_h_v, r_i_v, r_j_v;
    t_pp                r_g_pp1, r_g_pp2, r_g_ppl;
    logic               r_g_n1, r_g_n2, r_g_nl;
    logic [63:0]        r_g_diff;
    t_side              r_g_side, r_h_side, r_i_side, r_j_side;
    logic signed [127:0] r_h_p1, r_h_p2, r_h_pl, r_i_num, r_i_lin;
    logic signed [63:0] r_h_diff;
    logic [127:0]       h_s1, h_s2, h_sl, r_j_mag;
    logic signed [127:0] i_diff;
    logic               r_j_neg;
    t_sat               r_j_lin;
    t_side              g_side;

    assign g_side = r_side_dly[SIDE_DLY-1];
    assign h_s1   = pp_sum(r_g_pp1);
    assign h_s2   = pp_sum(r_g_pp2);
    assign h_sl   = pp_sum(r_g_ppl);
    assign i_diff = 128'(r_h_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
        end else begin
            r_g_v <= ash_s_v & ash_a_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_j_v <= r_i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_pp1  <= pp_mul(mag64(ash_s_val), {1'b0, ash_s_hyp});
        r_g_pp2  <= pp_mul(mag64(ash_a_val), {1'b0, ash_a_hyp});
        r_g_ppl  <= pp_mul({1'b0, ash_a_hyp}, mag64(64'($signed(g_side.x))));
        r_g_n1   <= ash_s_val[63];
        r_g_n2   <= ash_a_val[63];
        r_g_nl   <= g_side.x[31];
        r_g_diff <= ash_s_ash - ash_a_ash;
        r_g_side <= g_side;
        r_h_p1   <= r_g_n1 ? -$signed(h_s1) : $signed(h_s1);
        r_h_p2   <= r_g_n2 ? -$signed(h_s2) : $signed(h_s2);
        r_h_pl   <= r_g_nl ? -$signed(h_sl) : $signed(h_sl);
        r_h_diff <= r_g_diff;
        r_h_side <= r_g_side;
        r_i_num  <= (r_h_p1 - r_h_p2 + (i_diff <<< INT_FRAC)) >>> LEN_DROP;
        r_i_lin  <= r_h_pl >>> INT_FRAC;
        r_i_side <= r_h_side;
        r_j_neg  <= r_i_num[127] ^ r_a2[COEF_W-1];
        r_j_mag  <= r_i_num[127] ? 128'(-r_i_num) : 128'(r_i_num);
        r_j_lin  <= sat32(r_i_lin);
        r_j_side <= r_i_side;
    end

    // quotient by |a2|, one bit a stage; index 0 holds the range check
    logic              r_dv_v   [0:DIV_STEPS];
    logic [REM_W-1:0]  r_dv_rem [0:DIV_STEPS];
    logic [31:0]       r_dv_q   [0:DIV_STEPS];
    t_tail             r_dv_t   [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_j_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_rem[0] <= r_j_mag[REM_W-1:0];
        r_dv_q[0]   <= '0;
        r_dv_t[0]   <= '{side: r_j_side, neg: r_j_neg,
                         big: (r_j_mag >= ({80'd0, a2_mag} << DIV_STEPS)), lin: r_j_lin};
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        logic [REM_W-1:0] dv;
        assign dv = {{DIV_STEPS{1'b0}}, a2_mag} << (DIV_STEPS - j);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_t[j] <= r_dv_t[j-1];
            if (r_dv_rem[j-1] >= dv) begin
                r_dv_rem[j] <= r_dv_rem[j-1] - dv;
                r_dv_q[j]   <= r_dv_q[j-1] | (32'd1 << (DIV_STEPS - j));
            end else begin
                r_dv_rem[j] <= r_dv_rem[j-1];
                r_dv_q[j]   <= r_dv_q[j-1];
            end
        end
    end

    // result selection and output register
    t_tail               fin;
    logic [127:0]        fin_mag;
    logic signed [127:0] fin_len;
    t_sat                fin_cf, fin_sel;

    assign fin     = r_dv_t[DIV_STEPS];
    assign fin_mag = fin.big ? (128'd1 << 40) : {96'd0, r_dv_q[DIV_STEPS]};
    assign fin_len = fin.neg ? -$signed(fin_mag) : $signed(fin_mag);
    assign fin_cf  = sat32(fin_len);
    assign fin_sel = (r_a2 == '0) ? fin.lin : fin_cf;

    logic        r_done, r_ovf;
    logic [31:0] r_value, r_slope, r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_slope <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
        end else if (r_dv_v[DIV_STEPS]) begin
            r_value <= fin.side.value;
            r_slope <= fin.side.slope;
            r_len   <= fin_sel.val;
            r_ovf   <= fin.side.ovf | fin_sel.ovf;
        end
    end

    assign o_done        = r_done;
    assign o_trace_value = r_value;
    assign o_trace_slope = r_slope;
    assign o_path_length = r_len;
    assign o_overflow    = r_ovf;

endmodule

@@ hw/rtl/qte_checker.sv @@
// Port-level checks for quadratic_trace_evaluator, bound to the top level.
// Depends on qte_pkg for the pipeline latency.
module qte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_trace_value,
    input logic [31:0] o_path_length
);
    import qte_pkg::*;

    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_done)
        else $error("item not delivered after pipeline latency");

    // no result without a matching item
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without accepted item");

    // value and length results only change together with the strobe
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> ($stable(o_path_length) && $stable(o_trace_value)))
        else $error("result ports moved without strobe");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("strobe after reset");

endmodule

bind quadratic_trace_evaluator qte_checker u_qte_checker (.*);
